[src/sbrt_pkg.sv]
package sbrt_pkg;

	localparam int SLOTS_DEFAULT = 4;
	localparam int QDEPTH = 2;
	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [1:0] FUNC_OPEN  = 2'd0;
	localparam logic [1:0] FUNC_DATA  = 2'd1;
	localparam logic [1:0] FUNC_CLOSE = 2'd2;
	localparam logic [1:0] FUNC_CHECK = 2'd3;

	localparam logic [1:0] STAT_OK           = 2'd0;
	localparam logic [1:0] STAT_NOT_OPEN     = 2'd1;
	localparam logic [1:0] STAT_ALREADY_OPEN = 2'd2;
	localparam logic [1:0] STAT_FULL         = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] block_id;
		logic [31:0] packet_id;
		logic [15:0] data_length;
		logic        evict_en;
		logic [63:0] evict_limit;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slot;
		logic        in_sequence;
		logic [31:0] write_offset;
		logic        resend_valid;
		logic [31:0] resend_first;
		logic [31:0] resend_last;
		logic [15:0] resend_channel;
		logic        frame_ready;
	} res_t;

endpackage

[src/sbrt_front.sv]
module sbrt_front #(
	parameter int SLOTS = sbrt_pkg::SLOTS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [63:0]         block_id,
	input  logic [31:0]         packet_id,
	input  logic [15:0]         data_length,
	input  logic                q_full,
	output logic                q_push,
	output sbrt_pkg::req_t      q_req
);

	localparam logic [63:0] SPAN = 64'(SLOTS - 1);

	logic           valid_s1;
	sbrt_pkg::req_t req_s1;
	logic           accept;

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_req    = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify: eviction window for opens
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.func        <= func;
			req_s1.block_id    <= block_id;
			req_s1.packet_id   <= packet_id;
			req_s1.data_length <= data_length;
			req_s1.evict_en    <= (func == sbrt_pkg::FUNC_OPEN) && (block_id >= SPAN);
			req_s1.evict_limit <= block_id - SPAN;
		end
	end

endmodule

[src/sbrt_fifo.sv]
module sbrt_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbrt_pkg::req_t push_req,
	input  logic           pop,
	output sbrt_pkg::req_t head,
	output logic           nonempty,
	output logic           full
);

	sbrt_pkg::req_t                mem_q [sbrt_pkg::QDEPTH];
	logic [sbrt_pkg::QPW-1:0]      wr_ptr_q;
	logic [sbrt_pkg::QPW-1:0]      rd_ptr_q;
	logic [sbrt_pkg::QCW-1:0]      count_q;

	assign nonempty = count_q != '0;
	assign full     = count_q == sbrt_pkg::QCW'(sbrt_pkg::QDEPTH);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sbrt_pkg::QPW'(sbrt_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sbrt_pkg::QPW'(sbrt_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !nonempty))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");
`endif

endmodule

[src/sbrt_back.sv]
module sbrt_back #(
	parameter int SLOTS = sbrt_pkg::SLOTS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  sbrt_pkg::req_t head,
	input  logic           nonempty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output sbrt_pkg::res_t res
);

	localparam int SW = $clog2(SLOTS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVICT = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	sbrt_pkg::req_t    cur_q;
	logic [15:0]       channel_q;

	logic [SLOTS-1:0]  vld_q;
	logic [63:0]       blk_q  [SLOTS];
	logic [31:0]       last_q [SLOTS];
	logic [31:0]       off_q  [SLOTS];

	logic              hit_q;
	logic              full_q;
	logic [SW-1:0]     idx_q;
	logic [31:0]       rd_last_q;
	logic [31:0]       rd_off_q;

	logic              out_valid_q;
	sbrt_pkg::res_t    res_q;
	sbrt_pkg::res_t    res_d;

	logic [SLOTS-1:0]  match;
	logic              hit_d;
	logic [SW-1:0]     match_idx;
	logic [SW-1:0]     free_idx;
	logic              out_free;
	logic              exec_go;
	logic              wr_open;
	logic              wr_last;
	logic              wr_off;
	logic              older;
	logic [31:0]       nxt;

	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign exec_go   = (state_q == ST_EXEC) && out_free;
	assign pop       = nonempty && ((state_q == ST_IDLE) || exec_go);

	always_comb begin
		match     = '0;
		hit_d     = 1'b0;
		match_idx = '0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			match[i] = vld_q[i] && (blk_q[i] == cur_q.block_id);
			if (match[i]) begin
				hit_d     = 1'b1;
				match_idx = SW'(i);
			end
			if (!vld_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	always_comb begin
		res_d   = '0;
		wr_open = 1'b0;
		wr_last = 1'b0;
		wr_off  = 1'b0;
		older   = rd_last_q > cur_q.packet_id;
		nxt     = rd_last_q + 32'd1;
		if (cur_q.func == sbrt_pkg::FUNC_OPEN) begin
			if (hit_q) begin
				res_d.status = sbrt_pkg::STAT_ALREADY_OPEN;
				res_d.slot   = 3'(idx_q);
			end else if (full_q) begin
				res_d.status = sbrt_pkg::STAT_FULL;
			end else begin
				res_d.slot = 3'(idx_q);
				wr_open    = 1'b1;
			end
		end else if (!hit_q) begin
			res_d.status = sbrt_pkg::STAT_NOT_OPEN;
		end else begin
			res_d.slot = 3'(idx_q);
			if (cur_q.func == sbrt_pkg::FUNC_CLOSE) begin
				res_d.frame_ready = 1'b1;
			end else begin
				if (older || (cur_q.packet_id == nxt)) begin
					res_d.in_sequence = 1'b1;
				end else begin
					res_d.resend_valid   = 1'b1;
					res_d.resend_first   = nxt;
					res_d.resend_last    = cur_q.packet_id - 32'd1;
					res_d.resend_channel = channel_q;
				end
				wr_last = !older;
				if (cur_q.func == sbrt_pkg::FUNC_DATA) begin
					res_d.write_offset = rd_off_q;
					wr_off             = 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_EXEC: begin
				if (pop) begin
					state_d = (head.func == sbrt_pkg::FUNC_OPEN) ? ST_EVICT : ST_LOOK;
				end else if (exec_go) begin
					state_d = ST_IDLE;
				end
			end
			ST_EVICT: state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			channel_q   <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				channel_q <= cfg_wdata;
			end
			if (state_q == ST_EVICT && cur_q.evict_en) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (vld_q[i] && (blk_q[i] <= cur_q.evict_limit)) begin
						vld_q[i] <= 1'b0;
					end
				end
			end
			if (exec_go && wr_open) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == ST_LOOK) begin
			hit_q  <= hit_d;
			full_q <= &vld_q;
			idx_q  <= hit_d ? match_idx : free_idx;
		end
		if (state_q == ST_READ) begin
			rd_last_q <= last_q[idx_q];
			rd_off_q  <= off_q[idx_q];
		end
		if (exec_go) begin
			res_q <= res_d;
			if (wr_open) begin
				blk_q[idx_q]  <= cur_q.block_id;
				last_q[idx_q] <= 32'd1;
				off_q[idx_q]  <= 32'd0;
			end
			if (wr_last) begin
				last_q[idx_q] <= cur_q.packet_id;
			end
			if (wr_off) begin
				off_q[idx_q] <= rd_off_q + 32'(cur_q.data_length);
			end
		end
	end

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n) exec_go |=> out_valid_q)
		else $error("executed request produced no result");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE || state_q == ST_EXEC))
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> (!hit_q || vld_q[idx_q]))
		else $error("hit on a free slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && wr_open) |=> vld_q[$past(idx_q)])
		else $error("opened slot not marked valid");
`endif

endmodule

[src/stream_block_reassembly_tracker.sv]
// Tracks up to SLOTS open image blocks and answers each request with one result.
// A request enters a one-stage front register, then a two-entry queue, and is
// carried out by a sequencer that owns the slot table: data, check and close
// requests pass through lookup, table read and execute, open requests through
// an eviction pass first. A new request leaves the queue only as the current
// one executes, and execution waits until the last result is taken. Slots are
// reported as 0 when none applies; the lowest matching slot wins on duplicates.
module stream_block_reassembly_tracker #(
	parameter int SLOTS = sbrt_pkg::SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] block_id,
	input  logic [31:0] packet_id,
	input  logic [15:0] data_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  slot,
	output logic        in_sequence,
	output logic [31:0] write_offset,
	output logic        resend_valid,
	output logic [31:0] resend_first,
	output logic [31:0] resend_last,
	output logic [15:0] resend_channel,
	output logic        frame_ready
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_nonempty;
	sbrt_pkg::req_t q_req;
	sbrt_pkg::req_t q_head;
	sbrt_pkg::res_t res;

	sbrt_front #(.SLOTS(SLOTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.block_id    (block_id),
		.packet_id   (packet_id),
		.data_length (data_length),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_req       (q_req)
	);

	sbrt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (q_req),
		.pop      (q_pop),
		.head     (q_head),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	sbrt_back #(.SLOTS(SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (q_head),
		.nonempty  (q_nonempty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign status         = res.status;
	assign slot           = res.slot;
	assign in_sequence    = res.in_sequence;
	assign write_offset   = res.write_offset;
	assign resend_valid   = res.resend_valid;
	assign resend_first   = res.resend_first;
	assign resend_last    = res.resend_last;
	assign resend_channel = res.resend_channel;
	assign frame_ready    = res.frame_ready;

endmodule

[verif/stream_block_reassembly_tracker_test.sv]
module stream_block_reassembly_tracker_test;

	localparam int SLOTS = sbrt_pkg::SLOTS_DEFAULT;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_PACKETS = 16;
	localparam int PHASE_REQUESTS = 90;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [63:0] block_id;
	logic [31:0] packet_id;
	logic [15:0] data_length;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [2:0]  slot;
	logic        in_sequence;
	logic [31:0] write_offset;
	logic        resend_valid;
	logic [31:0] resend_first;
	logic [31:0] resend_last;
	logic [15:0] resend_channel;
	logic        frame_ready;

	logic        tbl_valid [SLOTS];
	logic [63:0] tbl_block [SLOTS];
	logic [31:0] tbl_last_pkt [SLOTS];
	logic [31:0] tbl_offset [SLOTS];
	logic [1:0]  tbl_closed_slot;
	logic [15:0] tbl_channel;

	sbrt_pkg::res_t pending_results [$];
	logic [63:0] traffic_base;
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;
	int          mismatch_count = 0;
	int          requests_sent = 0;
	int          results_seen = 0;
	int          resends_seen = 0;
	int          closes_seen = 0;
	int          full_seen = 0;
	int          channel_writes = 0;
	int          quiet_cycles = 0;

	stream_block_reassembly_tracker #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.block_id(block_id),
		.packet_id(packet_id),
		.data_length(data_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot(slot),
		.in_sequence(in_sequence),
		.write_offset(write_offset),
		.resend_valid(resend_valid),
		.resend_first(resend_first),
		.resend_last(resend_last),
		.resend_channel(resend_channel),
		.frame_ready(frame_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int find_open_block(logic [63:0] bid);
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_valid[i] && tbl_block[i] == bid)
				return i;
		end
		return -1;
	endfunction

	function automatic void check_sequence(int s, logic [31:0] pid,
			inout sbrt_pkg::res_t r);
		logic [31:0] next_pid;
		next_pid = tbl_last_pkt[s] + 32'd1;
		if (tbl_last_pkt[s] > pid) begin
			r.in_sequence = 1'b1;
			return;
		end
		if (pid == next_pid) begin
			r.in_sequence = 1'b1;
		end else begin
			r.resend_valid = 1'b1;
			r.resend_first = next_pid;
			r.resend_last = pid - 32'd1;
			r.resend_channel = tbl_channel;
		end
		tbl_last_pkt[s] = pid;
	endfunction

	function automatic sbrt_pkg::res_t predict_tracker(logic [1:0] f, logic [63:0] bid,
			logic [31:0] pid, logic [15:0] len);
		sbrt_pkg::res_t r;
		int          hit;
		int          free_slot;
		logic [63:0] span;
		r = '0;
		span = 64'(SLOTS - 1);
		if (f == sbrt_pkg::FUNC_OPEN) begin
			if (bid >= span) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i] && tbl_block[i] <= bid - span) begin
						tbl_valid[i] = 1'b0;
						tbl_block[i] = '0;
						tbl_last_pkt[i] = '0;
						tbl_offset[i] = '0;
					end
				end
			end
			hit = find_open_block(bid);
			if (hit >= 0) begin
				r.status = sbrt_pkg::STAT_ALREADY_OPEN;
				r.slot = 3'(hit);
				return r;
			end
			free_slot = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (!tbl_valid[i] && free_slot < 0)
					free_slot = i;
			end
			if (free_slot < 0) begin
				r.status = sbrt_pkg::STAT_FULL;
				return r;
			end
			tbl_valid[free_slot] = 1'b1;
			tbl_block[free_slot] = bid;
			tbl_last_pkt[free_slot] = 32'd1;
			tbl_offset[free_slot] = '0;
			r.slot = 3'(free_slot);
			return r;
		end
		hit = find_open_block(bid);
		if (hit < 0) begin
			r.status = sbrt_pkg::STAT_NOT_OPEN;
			return r;
		end
		r.slot = 3'(hit);
		case (f)
			sbrt_pkg::FUNC_DATA: begin
				check_sequence(hit, pid, r);
				r.write_offset = tbl_offset[hit];
				tbl_offset[hit] = tbl_offset[hit] + 32'(len);
			end
			sbrt_pkg::FUNC_CHECK: begin
				check_sequence(hit, pid, r);
			end
			default: begin
				tbl_closed_slot = 2'(hit);
				r.frame_ready = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (got_v !== want_v) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d: %s expected %0h, got %0h", results_seen, name,
					want_v, got_v);
		end
	endfunction

	always @(posedge clk) begin : check_results
		sbrt_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with no request outstanding", results_seen);
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("slot", want.slot, slot);
				check_field("in_sequence", want.in_sequence, in_sequence);
				check_field("write_offset", want.write_offset, write_offset);
				check_field("resend_valid", want.resend_valid, resend_valid);
				check_field("resend_first", want.resend_first, resend_first);
				check_field("resend_last", want.resend_last, resend_last);
				check_field("resend_channel", want.resend_channel, resend_channel);
				check_field("frame_ready", want.frame_ready, frame_ready);
				if (want.resend_valid)
					resends_seen++;
				if (want.frame_ready)
					closes_seen++;
				if (want.status == sbrt_pkg::STAT_FULL)
					full_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 15);
			end
		end
	end

	task automatic send_request(logic [1:0] f, logic [63:0] bid, logic [31:0] pid,
			logic [15:0] len);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		block_id <= bid;
		packet_id <= pid;
		data_length <= len;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_tracker(f, bid, pid, len));
		requests_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_stream_channel(logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tbl_channel = value;
		channel_writes++;
	endtask

	task automatic random_request();
		int          pick;
		int          s;
		logic [1:0]  f;
		logic [63:0] bid;
		logic [31:0] pid;
		logic [15:0] len;
		pick = $urandom_range(99);
		if (pick < 20)
			f = sbrt_pkg::FUNC_OPEN;
		else if (pick < 70)
			f = sbrt_pkg::FUNC_DATA;
		else if (pick < 85)
			f = sbrt_pkg::FUNC_CHECK;
		else
			f = sbrt_pkg::FUNC_CLOSE;
		pick = $urandom_range(99);
		if (pick < 85)
			bid = traffic_base + 64'($urandom_range(0, 4));
		else if (pick < 95)
			bid = {$urandom, $urandom};
		else
			bid = tbl_block[$urandom_range(0, SLOTS - 1)];
		s = find_open_block(bid);
		pick = $urandom_range(99);
		if (s < 0 || pick >= 90)
			pid = $urandom;
		else if (pick < 70)
			pid = tbl_last_pkt[s] + 32'd1;
		else if (pick < 80)
			pid = tbl_last_pkt[s] - 32'($urandom_range(1, 3));
		else
			pid = tbl_last_pkt[s] + 32'($urandom_range(2, 6));
		pick = $urandom_range(99);
		if (pick < 80)
			len = 16'($urandom_range(0, 1500));
		else if (pick < 95)
			len = 16'($urandom);
		else
			len = 16'hFFFF;
		if ($urandom_range(99) < 8)
			traffic_base = traffic_base + 64'd1;
		send_request(f, bid, pid, len);
	endtask

	task automatic test_open_and_full();
		send_request(sbrt_pkg::FUNC_OPEN, 64'd10, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd11, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd12, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd13, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd11, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd5, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd1, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd14, 32'd0, 16'd0);
	endtask

	task automatic test_sequence_check();
		wait_for_results();
		write_stream_channel(16'hFFFF);
		send_request(sbrt_pkg::FUNC_DATA, 64'd12, 32'd2, 16'hFFFF);
		send_request(sbrt_pkg::FUNC_DATA, 64'd12, 32'd2, 16'd0);
		send_request(sbrt_pkg::FUNC_DATA, 64'd12, 32'd10, 16'd100);
		send_request(sbrt_pkg::FUNC_DATA, 64'd12, 32'd5, 16'd7);
		send_request(sbrt_pkg::FUNC_CHECK, 64'd12, 32'd11, 16'd0);
		send_request(sbrt_pkg::FUNC_CHECK, 64'd12, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(sbrt_pkg::FUNC_CHECK, 64'd12, 32'd0, 16'd0);
	endtask

	task automatic test_unknown_and_close();
		send_request(sbrt_pkg::FUNC_DATA, 64'd99, 32'd2, 16'd64);
		send_request(sbrt_pkg::FUNC_CHECK, 64'd99, 32'd2, 16'd0);
		send_request(sbrt_pkg::FUNC_CLOSE, 64'd99, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_CLOSE, 64'd12, 32'd0, 16'd0);
		send_request(sbrt_pkg::FUNC_DATA, 64'd12, 32'd1, 16'd32);
		send_request(sbrt_pkg::FUNC_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(sbrt_pkg::FUNC_OPEN, 64'd0, 32'd0, 16'd0);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			wait_for_results();
			write_stream_channel(16'($urandom));
			case (phase)
				0: traffic_base = 64'd100;
				1: traffic_base = 64'd0;
				3: traffic_base = 64'hFFFF_FFFF_FFFF_FFF8;
				default: traffic_base = {$urandom, $urandom};
			endcase
			calm = (phase == 2);
			repeat (PHASE_REQUESTS) random_request();
			calm = 1'b0;
		end
	endtask

	task automatic test_long_packets();
		int s;
		wait_for_results();
		write_stream_channel(16'h0000);
		calm = 1'b1;
		send_request(sbrt_pkg::FUNC_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 16'd0);
		s = find_open_block(64'hFFFF_FFFF_FFFF_FFFF);
		for (int n = 0; n < LONG_PACKETS; n++)
			send_request(sbrt_pkg::FUNC_DATA, 64'hFFFF_FFFF_FFFF_FFFF,
				tbl_last_pkt[s] + 32'd1, 16'hFFFF);
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_for_results();
		write_stream_channel(16'($urandom));
		traffic_base = 64'd5000;
		calm = 1'b1;
		hold_request = 1'b1;
		repeat (24) random_request();
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = sbrt_pkg::FUNC_OPEN;
		block_id = '0;
		packet_id = '0;
		data_length = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_block[i] = '0;
			tbl_last_pkt[i] = '0;
			tbl_offset[i] = '0;
		end
		tbl_closed_slot = '0;
		tbl_channel = '0;
		traffic_base = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_open_and_full();
		test_sequence_check();
		test_unknown_and_close();
		test_random_traffic();
		test_long_packets();
		test_backpressure();
		wait_for_results();

		$display("Sent %0d requests and checked %0d results over %0d channel settings.",
			requests_sent, results_seen, channel_writes);
		$display("Saw %0d resend requests, %0d closes, %0d table-full answers, long packets.",
			resends_seen, closes_seen, full_seen);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
src/sbrt_pkg.sv
src/sbrt_front.sv
src/sbrt_fifo.sv
src/sbrt_back.sv
src/stream_block_reassembly_tracker.sv
verif/stream_block_reassembly_tracker_test.sv
